/* src/ncsc_pkg.sv */
// Shared types, constants and character classes for the nested call syntax checker.
`timescale 1ns / 1ps
`default_nettype none

package ncsc_pkg;

    localparam int MAX_DEPTH = 255;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_NAME   = 5'b00010,
        PH_OPEN   = 5'b00100,
        PH_COMMA  = 5'b01000,
        PH_CLOSED = 5'b10000
    } phase_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

/* src/nested_call_syntax_checker.sv */
// Verdict path: an end-marker transfer is held in the single input register, and its
// verdict is written into the result register and presented from there.
// Throughput: one transfer per cycle; character transfers produce no result. A stalled
// result holds back a following end marker and the transfers queued behind it.
// Reset (aresetn low, synchronous) empties both registers and returns the parser to
// its start state.
`timescale 1ns / 1ps
`default_nettype none

module nested_call_syntax_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    input  wire logic       s_tlast,   // end_marker
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] accepted, [1] too_deep, [7:2] zero
);
    import ncsc_pkg::*;

    logic               in_vld_reg;
    logic [7:0]         in_char_reg;
    logic               in_last_reg;

    phase_t             phase_reg,  phase_next;
    logic [DEPTH_W-1:0] depth_reg,  depth_next;
    logic               ident_reg,  ident_next;
    logic               failed_reg, failed_next;
    logic               ovf_reg,    ovf_next;

    logic               out_vld_reg;
    logic               acc_reg, acc_next;
    logic               deep_reg, deep_next;

    logic               out_free;
    logic               proceed;
    logic               ok;
    logic [7:0]         c;

    assign out_free = !out_vld_reg || m_tready;
    // A character never waits; an end marker needs a free result slot.
    assign proceed  = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || proceed;

    assign c  = in_char_reg;
    assign ok = !failed_reg && (phase_reg == PH_CLOSED) && (depth_reg == '0);

    always_comb begin
        phase_next  = phase_reg;
        depth_next  = depth_reg;
        ident_next  = ident_reg;
        failed_next = failed_reg;
        ovf_next    = ovf_reg;
        acc_next    = ok;
        deep_next   = !ok && ovf_reg;
        if (proceed) begin
            if (in_last_reg) begin
                phase_next  = PH_START;
                depth_next  = '0;
                ident_next  = 1'b0;
                failed_next = 1'b0;
                ovf_next    = 1'b0;
            end else if (!failed_reg && !(ident_reg && (is_letter(c) || is_digit(c)))) begin
                ident_next = 1'b0;
                if (!is_space(c)) begin
                    unique case (phase_reg) inside
                        PH_START, PH_COMMA: begin
                            if (is_letter(c)) begin
                                phase_next = PH_NAME;
                                ident_next = 1'b1;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_OPEN: begin
                            if (c == CH_CLOSE) begin
                                if (depth_reg != '0) begin
                                    depth_next = depth_reg - 1'b1;
                                end
                                phase_next = PH_CLOSED;
                            end else if (is_letter(c)) begin
                                phase_next = PH_NAME;
                                ident_next = 1'b1;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_NAME: begin
                            if (c != CH_OPEN) begin
                                failed_next = 1'b1;
                            end else if (depth_reg >= DEPTH_W'(MAX_DEPTH)) begin
                                failed_next = 1'b1;
                                ovf_next    = 1'b1;
                            end else begin
                                depth_next = depth_reg + 1'b1;
                                phase_next = PH_OPEN;
                            end
                        end
                        PH_CLOSED: begin
                            if (depth_reg == '0) begin
                                failed_next = 1'b1;
                            end else if (c == CH_COMMA) begin
                                phase_next = PH_COMMA;
                            end else if (c == CH_CLOSE) begin
                                depth_next = depth_reg - 1'b1;
                                phase_next = PH_CLOSED;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                        default: begin
                            failed_next = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_START;
            depth_reg   <= '0;
            ident_reg   <= 1'b0;
            failed_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (out_free) begin
                out_vld_reg <= proceed && in_last_reg;
            end
            phase_reg  <= phase_next;
            depth_reg  <= depth_next;
            ident_reg  <= ident_next;
            failed_reg <= failed_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proceed && in_last_reg) begin
            acc_reg  <= acc_next;
            deep_reg <= deep_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, deep_reg, acc_reg};

endmodule

`default_nettype wire

/* src/ncsc_checker.sv */
// Port-level checks for the nested call syntax checker and their binding.
`timescale 1ns / 1ps
`default_nettype none

module ncsc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A stalled verdict must hold until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed while stalled");

    // An accepted string is never flagged as too deep.
    a_verdict_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("accepted and too_deep both set");

    // The padding bits of the result transfer stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'b0))
        else $error("result padding not zero");

    // Reset leaves no verdict pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind nested_call_syntax_checker ncsc_checker u_ncsc_checker (.*);

`default_nettype wire

/* tb/ncsc_verdict_checker.sv */
// Monitor, parse predictor and verdict scoreboard for the nested call syntax checker.
`timescale 1ns / 1ps

module ncsc_verdict_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    input  wire logic       s_tlast,   // end_marker
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,   // [0] accepted, [1] too_deep, [7:2] zero
    output int              mismatches,
    output int              outstanding
);
    import ncsc_pkg::*;

    typedef struct packed {
        logic too_deep;
        logic accepted;
    } verdict_t;

    verdict_t expected_verdicts[$];
    verdict_t want;
    verdict_t got;
    int       error_tally = 0;

    // Shadow of the parser state for the string currently being received.
    phase_t               grammar_phase;
    logic [DEPTH_W-1:0]   open_parens;
    logic                 reading_name;
    logic                 string_bad;
    logic                 depth_blown;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic logic char_alpha(input logic [7:0] c);
        logic [7:0] lower;
        lower = c | 8'h20;
        return (lower >= 8'h61) && (lower <= 8'h7A) && (c[7:6] == 2'b01);
    endfunction

    function automatic logic char_numeral(input logic [7:0] c);
        return (c[7:4] == 4'h3) && (c[3:0] <= 4'd9);
    endfunction

    function automatic logic char_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    task automatic clear_parse();
        grammar_phase = PH_START;
        open_parens   = '0;
        reading_name  = 1'b0;
        string_bad    = 1'b0;
        depth_blown   = 1'b0;
    endtask

    task automatic begin_name(input logic [7:0] c);
        if (char_alpha(c)) begin
            grammar_phase = PH_NAME;
            reading_name  = 1'b1;
        end else begin
            string_bad = 1'b1;
        end
    endtask

    task automatic close_level();
        if (open_parens != '0)
            open_parens = open_parens - 1'b1;
        grammar_phase = PH_CLOSED;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic skip;
        skip = string_bad;
        if (!skip && reading_name) begin
            if (char_alpha(c) || char_numeral(c))
                skip = 1'b1;
            else
                reading_name = 1'b0;
        end
        if (!skip && !char_blank(c)) begin
            case (grammar_phase) inside
                PH_START, PH_COMMA: begin
                    begin_name(c);
                end
                PH_OPEN: begin
                    if (c == CH_CLOSE)
                        close_level();
                    else
                        begin_name(c);
                end
                PH_NAME: begin
                    if (c != CH_OPEN) begin
                        string_bad = 1'b1;
                    end else if (open_parens >= MAX_DEPTH) begin
                        string_bad  = 1'b1;
                        depth_blown = 1'b1;
                    end else begin
                        open_parens   = open_parens + 1'b1;
                        grammar_phase = PH_OPEN;
                    end
                end
                PH_CLOSED: begin
                    // Once the outer term is closed, nothing but whitespace may follow.
                    if (open_parens == '0)
                        string_bad = 1'b1;
                    else if (c == CH_COMMA)
                        grammar_phase = PH_COMMA;
                    else if (c == CH_CLOSE)
                        close_level();
                    else
                        string_bad = 1'b1;
                end
                default: begin
                    string_bad = 1'b1;
                end
            endcase
        end
    endtask

    task automatic finish_string();
        verdict_t v;
        v.accepted = !string_bad && (grammar_phase == PH_CLOSED) && (open_parens == '0);
        v.too_deep = !v.accepted && depth_blown;
        expected_verdicts.push_back(v);
        clear_parse();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            expected_verdicts.delete();
        end else begin
            // Results are checked before the input side is taken in; a verdict can
            // never leave in the same cycle as its end marker arrives.
            if (m_tvalid && m_tready) begin
                got = m_tdata[1:0];
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result transfer: accepted=%0b too_deep=%0b",
                           got.accepted, got.too_deep);
                    error_tally++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
                        error_tally++;
                    end
                    if (got.too_deep !== want.too_deep) begin
                        $error("too_deep: expected %0b, got %0b", want.too_deep, got.too_deep);
                        error_tally++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("padding: expected %0h, got %0h", 6'd0, m_tdata[7:2]);
                        error_tally++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tlast)
                    finish_string();
                else
                    parse_char(s_tdata);
            end
        end
        mismatches  <= error_tally;
        outstanding <= expected_verdicts.size();
    end

endmodule

/* tb/tb_nested_call_syntax_checker.sv */
// Top of the nested call syntax checker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_nested_call_syntax_checker;
    import ncsc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CHARS = 400;
    localparam int MIN_STRINGS  = 16;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_code
    logic       s_tlast  = 1'b0;    // end_marker
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] accepted, [1] too_deep, [7:2] zero

    int         mismatches;
    int         outstanding;
    int         cycle_count = 0;
    int         chars_sent  = 0;
    logic       steady      = 1'b0;
    logic [7:0] frame[$];

    nested_call_syntax_checker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ncsc_verdict_checker scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 38);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Presents one transfer and returns at the edge where it is taken; tvalid stays high.
    task automatic drive_symbol(input logic [7:0] data, input logic last);
        while (!steady && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame[i]) drive_symbol(frame[i], 1'b0);
        // The character lane carries junk on the end marker; it must be ignored.
        drive_symbol(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
    endtask

    task automatic run_text(input string s);
        frame.delete();
        load_text(s);
        send_frame();
    endtask

    task automatic wait_for_verdicts();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
    endfunction

    task automatic add_gap();
        if ($urandom_range(9) < 3)
            repeat ($urandom_range(2, 1))
                frame.push_back($urandom_range(5) == 5 ? 8'h20 : 8'(9 + $urandom_range(4)));
    endtask

    task automatic add_name();
        frame.push_back(pick_letter());
        repeat ($urandom_range(4))
            frame.push_back($urandom_range(3) == 0 ? 8'h30 + 8'($urandom_range(9))
                                                   : pick_letter());
    endtask

    task automatic add_term(input int level);
        int nargs;
        add_gap();
        add_name();
        add_gap();
        frame.push_back(CH_OPEN);
        nargs = (level >= 4) ? 0 : $urandom_range(2);
        for (int k = 0; k < nargs; k++) begin
            if (k != 0) begin
                add_gap();
                frame.push_back(CH_COMMA);
            end
            add_term(level + 1);
        end
        add_gap();
        frame.push_back(CH_CLOSE);
        add_gap();
    endtask

    // Mostly well-formed terms, some with one defect, and some plain noise.
    task automatic build_random_frame();
        int         pick;
        int         pos;
        logic [7:0] mark;
        frame.delete();
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(12)) frame.push_back(8'($urandom_range(255)));
        end else begin
            add_term($urandom_range(4));
            if (pick >= 70) begin
                pos = $urandom_range(frame.size() - 1);
                case ($urandom_range(4))
                    0: frame[pos] = 8'($urandom_range(255));
                    1: frame.delete(pos);
                    2: frame.push_back(8'($urandom_range(255)));
                    3: while (frame.size() > pos) void'(frame.pop_back());
                    default: begin
                        case ($urandom_range(2))
                            0: mark = CH_OPEN;
                            1: mark = CH_CLOSE;
                            default: mark = CH_COMMA;
                        endcase
                        frame.insert(pos, mark);
                    end
                endcase
            end
        end
    endtask

    initial begin
        int strings_sent;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_text("");
        run_text("f()");
        run_text(" \tf ( ) \r\n\v\f");
        run_text("Zz9(a(),b1(c( )) , q())");
        run_text("f(");
        run_text("f(a");
        run_text("9()");
        run_text("f()x");
        run_text("f())");
        run_text("f(,)");
        run_text("f(a(),)");
        run_text("a b()");
        run_text("f)(a()");
        run_text("()");
        // Bytes at both ends of the code range and the upper half are never legal.
        frame.delete();
        load_text("f(");
        frame.push_back(8'h00);
        load_text(")");
        send_frame();
        frame.delete();
        load_text("f(a");
        frame.push_back(8'hFF);
        load_text("())");
        send_frame();
        frame.delete();
        load_text("g(");
        frame.push_back(8'h80);
        load_text(")");
        send_frame();
        // Every level up to the limit opens cleanly; the one beyond it is a depth rejection.
        frame.delete();
        repeat (MAX_DEPTH + 1) load_text("b(");
        send_frame();
        run_text("f()");
        wait_for_verdicts();

        strings_sent = 0;
        while (chars_sent < RANDOM_CHARS || strings_sent < MIN_STRINGS) begin
            steady = (strings_sent >= 4) && (strings_sent < 10);
            build_random_frame();
            chars_sent += frame.size();
            send_frame();
            strings_sent++;
            if (strings_sent % 15 == 0)
                wait_for_verdicts();
        end
        steady = 1'b0;

        wait_for_verdicts();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
